// ===== src/rgb_text_triplet_parser_assert.svh =====
// Assertion macros for the RGB text triplet parser
`ifndef RGB_TEXT_TRIPLET_PARSER_ASSERT_SVH
`define RGB_TEXT_TRIPLET_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RTP_ASSERT_IMP(lbl, ante, cons, msg)
`define RTP_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/rtp_pkg.sv =====
// Shared types and constants for the RGB text triplet parser
package rtp_pkg;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_TRAIL
  } phase_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;

  localparam logic [8:0] COMP_MAX = 9'd255;
  localparam logic [8:0] ACC_SAT  = 9'd256;

  localparam logic [1:0] IDX_RED   = 2'd0;
  localparam logic [1:0] IDX_GREEN = 2'd1;
  localparam logic [1:0] IDX_BLUE  = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] text_byte;
  } byte_beat_t;

endpackage

// ===== src/rtp_in_if.sv =====
// Input channel: one text byte per beat
interface rtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

// ===== src/rtp_out_if.sv =====
// Result channel: packed color and error flag per beat
interface rtp_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] packed_color;
  logic        format_error;

  modport source (output valid, output packed_color, output format_error, input ready);
  modport sink (input valid, input packed_color, input format_error, output ready);
endinterface

// ===== src/rtp_in_stage.sv =====
// Input register for incoming text bytes
module rtp_in_stage
  import rtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rtp_in_if.sink     in_ch,
  output byte_beat_t beat_o,
  input  logic       take_i
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  assign in_ch.ready = !valid_r || take_i;
  assign load        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = load ? 1'b1 : (take_i ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_ch.text_byte;
    end
  end

  assign beat_o.valid     = valid_r;
  assign beat_o.text_byte = byte_r;

endmodule

// ===== src/rtp_parse.sv =====
// Parser state, component accumulation and result register
module rtp_parse
  import rtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  byte_beat_t beat_i,
  output logic       take_o,
  rtp_out_if.source  out_ch
);

`include "rgb_text_triplet_parser_assert.svh"

  phase_t      phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [8:0]  acc_r, acc_nxt;
  logic        seen_r, seen_nxt;
  logic [7:0]  red_r, red_nxt;
  logic [7:0]  green_r, green_nxt;
  logic        err_r, err_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [23:0] color_r;
  logic        ferr_r;

  logic        is_nul, is_digit, is_space, is_comma;
  logic [3:0]  digit;
  logic [12:0] prod;
  logic [8:0]  acc_step;
  logic        fin;
  logic        ok;
  logic [23:0] color_nxt;

  assign is_nul   = (beat_i.text_byte == CH_NUL);
  assign is_space = (beat_i.text_byte == CH_SPACE);
  assign is_comma = (beat_i.text_byte == CH_COMMA);
  assign is_digit = (beat_i.text_byte >= CH_DIG0) && (beat_i.text_byte <= CH_DIG9);
  assign digit    = beat_i.text_byte[3:0];

  // Non-terminator bytes never wait; the terminator waits for a free result slot
  assign take_o = beat_i.valid && (!is_nul || !out_valid_r || out_ch.ready);
  assign fin    = take_o && is_nul;

  // acc * 10 + digit, saturating above 255
  assign prod     = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {9'd0, digit};
  assign acc_step = (prod > {4'd0, COMP_MAX}) ? ACC_SAT : prod[8:0];

  always_comb begin
    phase_nxt = phase_r;
    if (fin) begin
      phase_nxt = PH_LEAD;
    end else if (take_o && !err_r) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (is_digit) phase_nxt = PH_DIGITS;
        end
        PH_DIGITS: begin
          if (is_space && idx_r == IDX_BLUE && seen_r) phase_nxt = PH_TRAIL;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  always_comb begin
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    err_nxt   = err_r;
    if (fin) begin
      idx_nxt   = IDX_RED;
      acc_nxt   = '0;
      seen_nxt  = 1'b0;
      red_nxt   = '0;
      green_nxt = '0;
      err_nxt   = 1'b0;
    end else if (take_o && !err_r) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (is_digit) begin
            acc_nxt  = {5'd0, digit};
            seen_nxt = 1'b1;
          end else if (!is_space) begin
            err_nxt = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            acc_nxt  = acc_step;
            seen_nxt = 1'b1;
          end else if (is_comma) begin
            if (!seen_r || idx_r == IDX_BLUE || acc_r > COMP_MAX) begin
              err_nxt = 1'b1;
            end else begin
              if (idx_r == IDX_RED) red_nxt = acc_r[7:0];
              else                  green_nxt = acc_r[7:0];
              idx_nxt  = idx_r + 2'd1;
              acc_nxt  = '0;
              seen_nxt = 1'b0;
            end
          end else if (!(is_space && idx_r == IDX_BLUE && seen_r)) begin
            err_nxt = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (!is_space) err_nxt = 1'b1;
        end
        default: err_nxt = 1'b1;
      endcase
    end
  end

  assign ok = !err_r && idx_r == IDX_BLUE && seen_r
              && (phase_r == PH_DIGITS || phase_r == PH_TRAIL)
              && acc_r <= COMP_MAX;
  assign color_nxt     = ok ? {red_r, green_r, acc_r[7:0]} : 24'd0;
  assign out_valid_nxt = fin ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      idx_r       <= IDX_RED;
      acc_r       <= '0;
      seen_r      <= 1'b0;
      red_r       <= '0;
      green_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      acc_r       <= acc_nxt;
      seen_r      <= seen_nxt;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      color_r <= color_nxt;
      ferr_r  <= !ok;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.packed_color = color_r;
  assign out_ch.format_error = ferr_r;

  `RTP_ASSERT_IMP(a_err_zero_color, out_valid_r && ferr_r, color_r == 24'd0, "error result carries a color")
  `RTP_ASSERT_NXT(a_fin_clears, fin, phase_r == PH_LEAD && idx_r == IDX_RED && !err_r, "terminator did not reset parser")
  `RTP_ASSERT_NXT(a_err_sticky, take_o && !is_nul && err_r, err_r, "error dropped before terminator")
  `RTP_ASSERT_IMP(a_acc_bound, 1'b1, acc_r <= ACC_SAT && idx_r != 2'd3, "accumulator or index out of range")

endmodule

// ===== src/rgb_text_triplet_parser.sv =====
// Top level of the RGB text triplet parser
//
//   channel  | dir | payload                              | handshake
//   in_ch    | in  | text_byte[7:0]                       | valid/ready
//   out_ch   | out | packed_color[23:0], format_error     | valid/ready
//
// One byte is accepted per cycle unless a zero byte waits on a full result register; each
// byte passes through the input register, and the zero byte's result then goes to the result register.
// Synchronous active-low reset returns the parser to the leading-space phase.
// Only the zero byte waits on a full result register; other bytes never stall.
// With out_ch.ready held low, input stops once the result register is full and the input register holds a zero byte.
module rgb_text_triplet_parser
  import rtp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rtp_in_if.sink    in_ch,
  rtp_out_if.source out_ch
);

  byte_beat_t beat;
  logic       take;

  rtp_in_stage u_in_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .beat_o (beat),
    .take_i (take)
  );

  rtp_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat_i (beat),
    .take_o (take),
    .out_ch (out_ch)
  );

endmodule

// ===== verif/tb_rgb_text_triplet_parser.sv =====
// Testbench for the RGB text triplet parser: directed and random color strings
module tb_rgb_text_triplet_parser;
  import rtp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [23:0] color;
    logic        err;
  } color_result_t;

  logic clk;
  logic rst_n;

  rtp_in_if  in_bus ();
  rtp_out_if out_bus ();

  rgb_text_triplet_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Parser shadow state
  phase_t     shadow_phase;
  logic [1:0] shadow_index;
  logic [8:0] shadow_acc;
  logic       shadow_seen;
  logic [7:0] shadow_red;
  logic [7:0] shadow_green;
  logic       shadow_err;

  color_result_t pending_colors[$];
  int fail_count = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_request = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.text_byte = CH_NUL;
    out_bus.ready = 1'b0;
  end

  function automatic void clear_shadow();
    shadow_phase = PH_LEAD;
    shadow_index = IDX_RED;
    shadow_acc = '0;
    shadow_seen = 1'b0;
    shadow_red = '0;
    shadow_green = '0;
    shadow_err = 1'b0;
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    int v;
    v = int'(shadow_acc) * 10 + int'(c - CH_DIG0);
    shadow_acc = (v > int'(COMP_MAX)) ? ACC_SAT : 9'(v);
    shadow_seen = 1'b1;
  endfunction

  function automatic void predict_text_byte(input logic [7:0] c);
    logic          is_digit;
    logic          ok;
    color_result_t res;
    is_digit = (c >= CH_DIG0) && (c <= CH_DIG9);
    if (c == CH_NUL) begin
      ok = !shadow_err && shadow_index == IDX_BLUE && shadow_seen
        && (shadow_phase == PH_DIGITS || shadow_phase == PH_TRAIL)
        && shadow_acc <= COMP_MAX;
      res.color = ok ? {shadow_red, shadow_green, shadow_acc[7:0]} : 24'd0;
      res.err = !ok;
      pending_colors.push_back(res);
      clear_shadow();
    end else if (!shadow_err) begin
      case (shadow_phase)
        PH_LEAD: begin
          if (c == CH_SPACE) begin
          end else if (is_digit) begin
            shadow_phase = PH_DIGITS;
            shadow_acc = '0;
            take_digit(c);
          end else begin
            shadow_err = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            take_digit(c);
          end else if (c == CH_COMMA) begin
            if (!shadow_seen || shadow_index >= IDX_BLUE || shadow_acc > COMP_MAX) begin
              shadow_err = 1'b1;
            end else begin
              if (shadow_index == IDX_RED) shadow_red = shadow_acc[7:0];
              else shadow_green = shadow_acc[7:0];
              shadow_index = shadow_index + 2'd1;
              shadow_acc = '0;
              shadow_seen = 1'b0;
            end
          end else if (c == CH_SPACE) begin
            if (shadow_index == IDX_BLUE && shadow_seen) shadow_phase = PH_TRAIL;
            else shadow_err = 1'b1;
          end else begin
            shadow_err = 1'b1;
          end
        end
        default: begin
          if (c != CH_SPACE) shadow_err = 1'b1;
        end
      endcase
    end
  endfunction

  // Predict on every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) predict_text_byte(in_bus.text_byte);
  end

  // Compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin
    color_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_colors.size() == 0) begin
        $error("unexpected result: packed_color %h format_error %b",
               out_bus.packed_color, out_bus.format_error);
        fail_count++;
      end else begin
        want = pending_colors.pop_front();
        if (out_bus.packed_color !== want.color) begin
          $error("packed_color mismatch: expected %h, actual %h",
                 want.color, out_bus.packed_color);
          fail_count++;
        end
        if (out_bus.format_error !== want.err) begin
          $error("format_error mismatch: expected %b, actual %b",
                 want.err, out_bus.format_error);
          fail_count++;
        end
      end
    end
  end

  // Result side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      out_bus.ready <= 1'b0;
      hold_request--;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.text_byte <= b;
    @(posedge clk);
    while (!(in_bus.valid && in_bus.ready)) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_NUL);
  endtask

  task automatic wait_drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  task automatic append_component(ref logic [7:0] txt[$]);
    int    pick;
    int    value;
    string digits;
    pick = $urandom_range(99);
    if (pick < 6) begin
      // long digit run, usually saturates
      repeat ($urandom_range(4, 7)) txt.push_back(8'(CH_DIG0 + $urandom_range(9)));
    end else begin
      if (pick < 14) value = $urandom_range(256, 999);
      else if (pick < 22) value = ($urandom_range(1) != 0) ? 255 : 0;
      else value = $urandom_range(255);
      if ($urandom_range(99) < 15) repeat ($urandom_range(1, 2)) txt.push_back(CH_DIG0);
      digits = $sformatf("%0d", value);
      for (int i = 0; i < digits.len(); i++) txt.push_back(digits[i]);
    end
  endtask

  task automatic make_color_text(ref logic [7:0] txt[$]);
    int kind;
    int op;
    int pos;
    txt.delete();
    kind = $urandom_range(99);
    if (kind < 90) begin
      repeat ($urandom_range(99) < 70 ? 0 : $urandom_range(1, 3)) txt.push_back(CH_SPACE);
      append_component(txt);
      txt.push_back(CH_COMMA);
      append_component(txt);
      txt.push_back(CH_COMMA);
      append_component(txt);
      repeat ($urandom_range(99) < 70 ? 0 : $urandom_range(1, 3)) txt.push_back(CH_SPACE);
      if (kind >= 70) begin
        // disturb an otherwise good string, which usually breaks it
        op = $urandom_range(4);
        pos = $urandom_range(txt.size());
        case (op)
          0: txt.insert(pos, 8'($urandom_range(1, 255)));
          1: txt.delete($urandom_range(txt.size() - 1));
          2: txt.insert(pos, CH_SPACE);
          3: txt.insert(pos, CH_COMMA);
          default: txt.push_back(CH_COMMA);
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic test_directed_formats();
    string cases[$];
    cases = '{"0,0,0", " 255,255,255 ", "007,08,9", "256,0,0", "0,0,0000000999",
              "1 ,2,3", "1, 2,3", "1,,3", ",1,2", "1,2,", "1,2,3,", "1,2,3x",
              "", "1,2", "1,2,3 4", "  ", "12,34,56  "};
    src_idle_pct = 0;
    snk_idle_pct = 0;
    foreach (cases[i]) send_text(cases[i]);
    send_byte(8'hFF);
    send_byte(CH_NUL);
    wait_drain();
  endtask

  task automatic test_random_strings(input int src_pct, input int snk_pct,
                                     input int byte_budget);
    logic [7:0] txt[$];
    int         sent;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < byte_budget) begin
      make_color_text(txt);
      foreach (txt[i]) send_byte(txt[i]);
      send_byte(CH_NUL);
      sent += txt.size() + 1;
    end
    wait_drain();
  endtask

  task automatic test_result_backpressure();
    logic [7:0] txt[$];
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request = 300;
    // keep offering strings while the result side is held off
    repeat (12) begin
      make_color_text(txt);
      foreach (txt[i]) send_byte(txt[i]);
      send_byte(CH_NUL);
    end
    wait_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    clear_shadow();
    test_directed_formats();
    test_random_strings(34, 50, 410);
    test_random_strings(50, 34, 410);
    test_random_strings(0, 0, 410);
    test_result_backpressure();
    in_bus.valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
